### src/assert_macros.svh
// assertion macros used by the console buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcs_pkg.sv
// types and constants of the text console buffer
`default_nettype none

package tcs_pkg;

  // request types
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // character and color codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;

  // one input request
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } tcs_in_item_t;

  // one result
  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    logic       scrolled;
  } tcs_out_item_t;

  // one screen cell as stored
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] color;
  } tcs_cell_t;

endpackage

`default_nettype wire

### src/tcs_in_if.sv
// request channel of the text console buffer
`default_nettype none

interface tcs_in_if import tcs_pkg::*; ();
  logic         valid;
  logic         ready;
  tcs_in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/tcs_out_if.sv
// result channel of the text console buffer
`default_nettype none

interface tcs_out_if import tcs_pkg::*; ();
  logic          valid;
  logic          ready;
  tcs_out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/tcs_cell_ram.sv
// single port screen cell memory with registered read data
`default_nettype none

module tcs_cell_ram import tcs_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire tcs_cell_t     wdata,
  output tcs_cell_t          rdata
);

  tcs_cell_t mem [DEPTH];
  tcs_cell_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/tcs_ctrl.sv
// cursor, row rotation and memory sequencing of the console buffer
`default_nettype none
`include "assert_macros.svh"

module tcs_ctrl import tcs_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80,
  parameter int DEPTH   = ROWS * COLUMNS,
  parameter int AW      = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    text_color,
  tcs_in_if.sink             in_chan,
  output logic               res_valid,
  input  wire logic          res_ready,
  output tcs_out_item_t      res_item,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output tcs_cell_t          mem_wdata,
  input  wire tcs_cell_t     mem_rdata
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam logic [RW:0]   ROWS_W    = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADDR   = 3'd2;
  localparam logic [2:0] S_ACCESS = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  tcs_in_item_t  item_r, item_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          in_range_r, in_range_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic          is_read;
  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  logic [RW:0]   row_sum;
  logic [RW-1:0] prow;
  logic          wrap;
  logic          last_row;
  logic          clr_last;

  // logical to physical row through the rotating top row
  always_comb begin
    is_read  = (item_r.req_type == REQ_READ);
    lrow     = is_read ? RW'(item_r.read_row) : cur_row_r;
    lcol     = is_read ? CW'(item_r.read_column) : cur_col_r;
    row_sum  = {1'b0, top_r} + {1'b0, lrow};
    prow     = (row_sum >= ROWS_W) ? RW'(row_sum - ROWS_W) : RW'(row_sum);
    wrap     = (item_r.char_code == NEWLINE_CODE) || (cur_col_r == LAST_COL);
    last_row = (cur_row_r == LAST_ROW);
    clr_last = (clr_cnt_r == LAST_COL);
  end

  // sequencer and cursor next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    addr_nxt      = addr_r;
    in_range_nxt  = in_range_r;
    scrolled_nxt  = scrolled_r;
    clr_addr_nxt  = clr_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    in_chan.ready = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = addr_r;
    mem_wdata     = '{ch: item_r.char_code, color: text_color};
    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '{ch: BLANK_CODE, color: RESET_COLOR};
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          item_nxt  = in_chan.data;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_nxt     = AW'(32'(prow) * COLUMNS + 32'(lcol));
        in_range_nxt = (32'(item_r.read_row) < ROWS) &&
                       (32'(item_r.read_column) < COLUMNS);
        state_nxt    = S_ACCESS;
      end
      S_ACCESS: begin
        scrolled_nxt = 1'b0;
        state_nxt    = S_DONE;
        if (is_read) begin
          mem_re = in_range_r;
        end else begin
          mem_we = (item_r.char_code != NEWLINE_CODE);
          if (!wrap) begin
            cur_col_nxt = cur_col_r + 1'b1;
          end else begin
            cur_col_nxt = '0;
            if (!last_row) begin
              cur_row_nxt = cur_row_r + 1'b1;
            end else begin
              // old top row becomes the new bottom row
              scrolled_nxt = 1'b1;
              clr_addr_nxt = AW'(32'(top_r) * COLUMNS);
              clr_cnt_nxt  = '0;
              state_nxt    = S_SCROLL;
            end
          end
        end
      end
      S_SCROLL: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '{ch: BLANK_CODE, color: text_color};
        clr_addr_nxt = clr_addr_r + 1'b1;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (clr_last) begin
          top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_item.cell_char     = (is_read && in_range_r) ? mem_rdata.ch : 8'h00;
    res_item.cell_color    = (is_read && in_range_r) ? mem_rdata.color : 8'h00;
    res_item.cursor_row    = 5'(cur_row_r);
    res_item.cursor_column = 7'(cur_col_r);
    res_item.scrolled      = scrolled_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      top_r      <= '0;
      scrolled_r <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      top_r      <= top_nxt;
      scrolled_r <= scrolled_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    addr_r     <= addr_nxt;
    in_range_r <= in_range_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
  end

  // every memory access lands inside the buffer
  `ASSERT_RST(a_addr_range, (mem_we || mem_re) |-> (32'(mem_addr) < DEPTH),
    "memory access outside the cell buffer")
  // rotating top row stays a valid row
  `ASSERT_RST(a_top_range, 32'(top_r) < ROWS, "top row pointer out of range")
  // a finished scroll leaves the cursor at the start of the bottom row
  `ASSERT_RST(a_scroll_cursor, (state_r == S_SCROLL && clr_last) |=>
    (cur_row_r == LAST_ROW && cur_col_r == '0 && scrolled_r),
    "cursor not on bottom row after scroll")

endmodule

`default_nettype wire

### src/text_console_cursor_scroll.sv
// top level of the text console buffer with color register and result register
//
//   channel   dir  handshake            contents
//   in_chan   in   valid/ready          req_type, char_code, read_row, read_column
//   out_chan  out  valid/ready          cell_char, cell_color, cursor, scrolled
//   cfg       in   cfg_wr_en, no wait   text_color
//
// a read or put request passes the address, memory access and result steps around
// the one-port cell ram before the next acceptance; the result step waits for a free output register
// a put that scrolls adds a step that clears the new bottom row, one cell
// per cycle; rows rotate through a top row pointer, so no row is copied
// after reset a clearing pass fills the whole buffer with blanks, in_chan idle
// a stalled result waits in the output register while the next request is taken
`default_nettype none

module text_console_cursor_scroll import tcs_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  tcs_in_if.sink          in_chan,
  tcs_out_if.source       out_chan
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    text_color_r;
  logic          out_valid_r, out_valid_nxt;
  tcs_out_item_t out_item_r;
  logic          res_valid;
  logic          res_ready;
  tcs_out_item_t res_item;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  tcs_cell_t     mem_wdata;
  tcs_cell_t     mem_rdata;

  // color register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_wr_en) begin
      text_color_r <= cfg_wr_data;
    end
  end

  // output register, free when empty or being taken
  assign res_ready     = !out_valid_r || out_chan.ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  // sequencer
  tcs_ctrl #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_color (text_color_r),
    .in_chan    (in_chan),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // cell memory
  tcs_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### dv/text_console_cursor_scroll_tb.sv
// self-checking testbench for the text console buffer: random put and read traffic
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;
  import tcs_pkg::*;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = SCREEN_COLS + 20;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  tcs_in_if in_chan ();
  tcs_out_if out_chan ();

  text_console_cursor_scroll #(
    .ROWS(SCREEN_ROWS),
    .COLUMNS(SCREEN_COLS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always #4 clk = ~clk;

  // requests waiting to be offered and results waiting to be checked
  tcs_in_item_t pending_reqs[$];
  tcs_out_item_t expected_results[$];

  // shadow copy of the screen, cursor and color
  tcs_cell_t screen_shadow [SCREEN_ROWS][SCREEN_COLS];
  int cur_row;
  int cur_col;
  logic [7:0] shadow_color;

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_kick;
  int hold_left;
  bit hold_used;
  int hold_blocked_cycles;

  int mismatch_count;
  int checked_count;
  int put_count;
  int read_count;
  int scroll_count;
  int off_screen_count;

  // next screen state and result for one accepted request
  function automatic tcs_out_item_t predict_result(tcs_in_item_t req);
    tcs_out_item_t res;
    logic next_line;
    res = '0;
    next_line = 1'b0;
    if (req.req_type == REQ_PUT) begin
      put_count++;
      if (req.char_code == NEWLINE_CODE) begin
        next_line = 1'b1;
      end else begin
        screen_shadow[cur_row][cur_col].ch = req.char_code;
        screen_shadow[cur_row][cur_col].color = shadow_color;
        cur_col++;
        if (cur_col >= SCREEN_COLS) next_line = 1'b1;
      end
      if (next_line) begin
        cur_col = 0;
        cur_row++;
        // past the bottom row: move everything up and blank the last row
        if (cur_row >= SCREEN_ROWS) begin
          for (int r = 0; r < SCREEN_ROWS - 1; r++) screen_shadow[r] = screen_shadow[r + 1];
          for (int c = 0; c < SCREEN_COLS; c++) begin
            screen_shadow[SCREEN_ROWS - 1][c].ch = BLANK_CODE;
            screen_shadow[SCREEN_ROWS - 1][c].color = shadow_color;
          end
          cur_row = SCREEN_ROWS - 1;
          res.scrolled = 1'b1;
          scroll_count++;
        end
      end
    end else begin
      read_count++;
      if (req.read_row < SCREEN_ROWS && req.read_column < SCREEN_COLS) begin
        res.cell_char = screen_shadow[req.read_row][req.read_column].ch;
        res.cell_color = screen_shadow[req.read_row][req.read_column].color;
      end else begin
        off_screen_count++;
      end
    end
    res.cursor_row = 5'(cur_row);
    res.cursor_column = 7'(cur_col);
    return res;
  endfunction

  function automatic tcs_in_item_t make_put(logic [7:0] code);
    tcs_in_item_t req;
    req.req_type = REQ_PUT;
    req.char_code = code;
    req.read_row = 5'($urandom);
    req.read_column = 7'($urandom);
    return req;
  endfunction

  function automatic tcs_in_item_t make_read(int row, int col);
    tcs_in_item_t req;
    req.req_type = REQ_READ;
    req.char_code = 8'($urandom);
    req.read_row = 5'(row);
    req.read_column = 7'(col);
    return req;
  endfunction

  function automatic logic [7:0] printable_code();
    logic [7:0] code;
    code = 8'($urandom);
    if (code == NEWLINE_CODE) code = 8'h2E;
    return code;
  endfunction

  // driver: offers the next pending request unless idling this cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_chan.valid <= 1'b1;
        in_chan.data <= pending_reqs.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long hold-off counter, kicked once by the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
      hold_blocked_cycles <= 0;
    end else begin
      if (hold_kick && !hold_used) begin
        hold_left <= HOLD_CYCLES;
        hold_used <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (hold_left > 0 && in_chan.valid && !in_chan.ready)
        hold_blocked_cycles <= hold_blocked_cycles + 1;
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin : monitor
    tcs_out_item_t want;
    tcs_out_item_t got;
    if (!rst_n) begin
      for (int r = 0; r < SCREEN_ROWS; r++)
        for (int c = 0; c < SCREEN_COLS; c++) begin
          screen_shadow[r][c].ch = BLANK_CODE;
          screen_shadow[r][c].color = RESET_COLOR;
        end
      cur_row = 0;
      cur_col = 0;
      shadow_color = RESET_COLOR;
    end else begin
      if (cfg_wr_en) shadow_color = cfg_wr_data;
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: char %h color %h row %0d col %0d scroll %0b",
                     got.cell_char, got.cell_color, got.cursor_row, got.cursor_column,
                     got.scrolled);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
              got.cursor_row !== want.cursor_row ||
              got.cursor_column !== want.cursor_column || got.scrolled !== want.scrolled) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d: expected char %h color %h row %0d col %0d scroll %0b",
                       checked_count, want.cell_char, want.cell_color, want.cursor_row,
                       want.cursor_column, want.scrolled);
              $display("result %0d:      got char %h color %h row %0d col %0d scroll %0b",
                       checked_count, got.cell_char, got.cell_color, got.cursor_row,
                       got.cursor_column, got.scrolled);
            end
          end
        end
      end
      if (in_chan.valid && in_chan.ready) expected_results.push_back(predict_result(in_chan.data));
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_chan.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // color change only once the block is idle, scroll clearing included
  task automatic set_color(logic [7:0] color);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly text lines and scanout reads, some newline runs and raw noise
  task automatic add_traffic(int count);
    int added;
    int pick;
    int len;
    tcs_in_item_t req;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 20);
        for (int i = 0; i < len; i++) pending_reqs.push_back(make_put(printable_code()));
        added += len;
        if ($urandom_range(0, 2) != 0) begin
          pending_reqs.push_back(make_put(NEWLINE_CODE));
          added++;
        end
      end else if (pick < 80) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          pending_reqs.push_back(make_read($urandom_range(0, SCREEN_ROWS - 1),
                                           $urandom_range(0, SCREEN_COLS - 1)));
        added += len;
      end else if (pick < 90) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) pending_reqs.push_back(make_put(NEWLINE_CODE));
        added += len;
      end else begin
        req = tcs_in_item_t'($urandom);
        pending_reqs.push_back(req);
        added++;
      end
    end
  endtask

  initial begin : stimulus
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    hold_kick = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    checked_count = 0;
    put_count = 0;
    read_count = 0;
    scroll_count = 0;
    off_screen_count = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, blank cells, newline, off-screen reads
    pending_reqs.push_back(make_put(8'h48));
    pending_reqs.push_back(make_put(8'h00));
    pending_reqs.push_back(make_put(8'hFF));
    pending_reqs.push_back(make_read(0, 0));
    pending_reqs.push_back(make_read(0, 1));
    pending_reqs.push_back(make_read(0, 2));
    pending_reqs.push_back(make_read(0, 3));
    pending_reqs.push_back(make_put(NEWLINE_CODE));
    pending_reqs.push_back(make_put(8'h80));
    pending_reqs.push_back(make_put(8'h7F));
    pending_reqs.push_back(make_read(1, 0));
    pending_reqs.push_back(make_read(1, 1));
    pending_reqs.push_back(make_read(SCREEN_ROWS - 1, SCREEN_COLS - 1));
    pending_reqs.push_back(make_read(SCREEN_ROWS, 0));
    pending_reqs.push_back(make_read(0, SCREEN_COLS));
    pending_reqs.push_back(make_read(31, 127));
    pending_reqs.push_back('{req_type: REQ_READ, char_code: NEWLINE_CODE,
                             read_row: 5'd0, read_column: 7'd0});
    pending_reqs.push_back('{req_type: REQ_PUT, char_code: 8'h41,
                             read_row: 5'd31, read_column: 7'd127});
    pending_reqs.push_back(make_put(NEWLINE_CODE));
    pending_reqs.push_back(make_read(2, 0));

    // traffic phases with a different color and idling pattern each
    set_color(8'h00);
    add_traffic(200);
    set_color(8'hFF);
    send_idle_pct = 53;
    add_traffic(200);
    set_color(8'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 53;
    add_traffic(200);
    set_color(8'($urandom));
    send_idle_pct = 23;
    recv_stall_pct = 23;
    add_traffic(200);

    // back-pressure: output held off while requests keep coming
    set_color(8'h1E);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_traffic(200);
    hold_kick = 1'b1;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count += expected_results.size();

    $display("checked %0d results: %0d puts, %0d reads (%0d off screen), %0d scrolls",
             checked_count, put_count, read_count, off_screen_count, scroll_count);
    $display("five color settings, mixed idling, %0d input cycles blocked by the output hold",
             hold_blocked_cycles);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #16_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
